### sv/sbem_pkg.sv
// Types and constants for the spectrum band energy meter.
// No dependencies.
`default_nettype none
package sbem_pkg;
	localparam logic [43:0] SUM_MAX = 44'hFFF_FFFF_FFFF;
	localparam logic [12:0] COUNT_MAX = 13'd8191;
	localparam logic [31:0] PEAK_FLOOR = 32'd16777;
	localparam logic [31:0] PEAK_DECAY = 32'd4294537799;
	localparam logic [15:0] SECTION_THRESH = 16'd9830;
	localparam logic [15:0] W_LOW = 16'd19661;
	localparam logic [15:0] W_MID = 16'd16384;
	localparam logic [15:0] W_HIGH = 16'd9830;

	localparam logic [2:0] REG_SUB_EDGE = 3'd0;
	localparam logic [2:0] REG_BASS_EDGE = 3'd1;
	localparam logic [2:0] REG_MID_EDGE = 3'd2;
	localparam logic [2:0] REG_FAST_ALPHA = 3'd3;
	localparam logic [2:0] REG_SLOW_ALPHA = 3'd4;

	typedef struct packed {
		logic [2:0] index;
		logic [15:0] value;
	} cfg_t;
endpackage
`default_nettype wire

### sv/spectrum_band_energy_meter.sv
// Spectrum band energy meter top level: accumulation, sequenced end-of-frame maths.
// Depends on sbem_pkg.
//
// Bins are taken one per cycle until the marked last bin. The last bin starts
// an end-of-frame sequence on one shared unit. For each band it runs a 44/13-bit
// restoring divide (one quotient bit a cycle, after a load step) and a
// 64-bit integer square root (one result bit a cycle, after a load step).
// Then come four weighted products, a peak update (maximum, then decay), five
// 48/32 gain divides (each after a load step, skipped while the peak is not
// above its floor), five EMA steps and a section check. No bin is taken while
// the sequence runs. The result sits in an output register while the next
// frame accumulates. The sequence holds at its last step while that register
// is still full.
`default_nettype none
module spectrum_band_energy_meter #(
	parameter int MAX_BINS = 4096
) (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	output logic s_axis_tready,
	input wire [15:0] s_axis_tdata, // bin_magnitude
	input wire s_axis_tlast, // last_bin
	output logic m_axis_tvalid,
	input wire m_axis_tready,
	output logic [159:0] m_axis_tdata, // level_overall, level_sub_bass, level_bass,
	// level_mid, level_treble, avg_overall, avg_sub_bass, avg_bass,
	// avg_mid, avg_treble, 16 bits each from the lowest bit up
	output logic m_axis_tuser, // section_flag
	input wire cfg_valid,
	output logic cfg_ready,
	input wire sbem_pkg::cfg_t cfg_data
);
	import sbem_pkg::*;

	localparam int IW = $clog2(MAX_BINS);
	localparam logic [IW-1:0] IDX_TOP = IW'(MAX_BINS - 1);

	typedef enum logic [3:0] {
		ST_ACC, ST_DIV, ST_SQRT, ST_OVR_MUL, ST_PEAK, ST_GAIN,
		ST_EMA_A, ST_EMA_B, ST_SEC, ST_OUT
	} state_t;

	state_t state_q;
	logic [12:0] sub_edge_q, bass_edge_q, mid_edge_q;
	logic [15:0] fast_alpha_q, slow_alpha_q;
	logic [IW-1:0] bin_idx_q;
	logic [43:0] sums_q [4];
	logic [12:0] counts_q [4];
	logic [31:0] peak_q;
	logic [15:0] smooth_q [5];
	logic [15:0] sec_lvl_q, sec_ref_q;
	logic [31:0] lv_q [5];
	logic [15:0] gl_q [5];
	logic [2:0] b_q;
	logic [5:0] cnt_q;
	// shared divide / sqrt unit registers
	logic [63:0] rem_q;
	logic [63:0] num_q;
	logic [43:0] quo_q;
	logic [63:0] acc_q;
	logic changed_q;
	logic active_q;

	logic [1:0] band;
	logic [43:0] sq_sum;
	logic [44:0] sum_ext;
	logic [64:0] trial;
	logic [65:0] root_trial;
	logic [47:0] mac;
	logic [63:0] peak_prod;

	assign s_axis_tready = (state_q == ST_ACC);
	assign cfg_ready = 1'b1;

	always_comb begin
		if (13'(bin_idx_q) < sub_edge_q) band = 2'd0;
		else if (13'(bin_idx_q) < bass_edge_q) band = 2'd1;
		else if (13'(bin_idx_q) < mid_edge_q) band = 2'd2;
		else band = 2'd3;
		sum_ext = {1'b0, sums_q[band]} + 45'(32'(s_axis_tdata) * 32'(s_axis_tdata));
		sq_sum = sum_ext[44] ? SUM_MAX : sum_ext[43:0];
		// divide step: remainder shifted with next numerator bit against divisor
		trial = {rem_q[63:0], num_q[63]} - 65'(acc_q);
		// sqrt step: remainder*4 + two bits vs 4*root+1
		root_trial = {rem_q, num_q[63:62]} - {acc_q[63:0], 2'b01};
		mac = 48'(smooth_q[b_q]) * 48'(17'h10000 - 17'(fast_alpha_q));
		peak_prod = 64'(peak_q) * 64'(PEAK_DECAY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			sub_edge_q <= 13'd2; bass_edge_q <= 13'd6; mid_edge_q <= 13'd86;
			fast_alpha_q <= 16'd8192; slow_alpha_q <= 16'd544;
			bin_idx_q <= '0;
			for (int i = 0; i < 4; i++) begin
				sums_q[i] <= '0; counts_q[i] <= '0;
			end
			for (int i = 0; i < 5; i++) begin
				smooth_q[i] <= '0; lv_q[i] <= '0; gl_q[i] <= '0;
			end
			peak_q <= PEAK_FLOOR;
			sec_lvl_q <= '0; sec_ref_q <= '0;
			m_axis_tvalid <= 1'b0;
			b_q <= '0; cnt_q <= '0;
			rem_q <= '0; num_q <= '0; quo_q <= '0; acc_q <= '0;
			changed_q <= 1'b0; active_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_data.index)
					REG_SUB_EDGE: sub_edge_q <= cfg_data.value[12:0];
					REG_BASS_EDGE: bass_edge_q <= cfg_data.value[12:0];
					REG_MID_EDGE: mid_edge_q <= cfg_data.value[12:0];
					REG_FAST_ALPHA: fast_alpha_q <= cfg_data.value;
					REG_SLOW_ALPHA: slow_alpha_q <= cfg_data.value;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				ST_ACC: if (s_axis_tvalid && s_axis_tready) begin
					if (bin_idx_q != '0) begin
						sums_q[band] <= sq_sum;
						if (counts_q[band] != COUNT_MAX) counts_q[band] <= counts_q[band] + 13'd1;
					end
					bin_idx_q <= (bin_idx_q == IDX_TOP) ? IDX_TOP : bin_idx_q + 1'b1;
					if (s_axis_tlast) begin
						b_q <= '0;
						cnt_q <= '0;
						rem_q <= '0; acc_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// band b: restoring divide of sum by count; cnt_q==0 loads
					if (cnt_q == 6'd0) begin
						num_q <= {sums_q[b_q[1:0]], 20'd0};
						acc_q <= 64'(counts_q[b_q[1:0]]);
						rem_q <= '0; quo_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						if (!trial[64]) rem_q <= trial[63:0];
						else rem_q <= {rem_q[62:0], num_q[63]};
						quo_q <= {quo_q[42:0], !trial[64]};
						num_q <= {num_q[62:0], 1'b0};
						if (cnt_q == 6'd44) begin
							cnt_q <= '0;
							state_q <= ST_SQRT;
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'd0) begin
						// mean, saturated to 32 bits, zero for an empty band
						if (acc_q == 64'd0) num_q <= '0;
						else if (quo_q[43:32] != '0) num_q <= 64'hFFFF_FFFF_0000_0000;
						else num_q <= {quo_q[31:0], 32'd0};
						rem_q <= '0; acc_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						if (!root_trial[65]) begin
							rem_q <= root_trial[63:0];
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= {rem_q[61:0], num_q[63:62]};
							acc_q <= {acc_q[62:0], 1'b0};
						end
						num_q <= {num_q[61:0], 2'b00};
						if (cnt_q == 6'd32) begin
							cnt_q <= '0;
							if (b_q == 3'd3) begin
								b_q <= '0;
								state_q <= ST_OVR_MUL;
							end else begin
								b_q <= b_q + 3'd1;
								state_q <= ST_DIV;
							end
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_OVR_MUL: begin
					// one weighted product per cycle into acc_q
					case (b_q)
						3'd0: acc_q <= 64'(lv_q[1]) * 64'(W_LOW);
						3'd1: acc_q <= acc_q + 64'(lv_q[2]) * 64'(W_LOW);
						3'd2: acc_q <= acc_q + 64'(lv_q[3]) * 64'(W_MID);
						default: acc_q <= acc_q + 64'(lv_q[4]) * 64'(W_HIGH);
					endcase
					if (b_q == 3'd3) begin
						b_q <= '0;
						state_q <= ST_PEAK;
					end else b_q <= b_q + 3'd1;
				end
				ST_PEAK: begin
					if (cnt_q == 6'd0) begin
						lv_q[0] <= acc_q[47:16];
						if (acc_q[47:16] > peak_q) peak_q <= acc_q[47:16];
						cnt_q <= 6'd1;
					end else begin
						peak_q <= peak_prod[63:32];
						active_q <= peak_prod[63:32] > PEAK_FLOOR;
						cnt_q <= '0; b_q <= '0;
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					if (!active_q) begin
						gl_q[b_q] <= lv_q[b_q][31:24] != '0 ? 16'hFFFF : lv_q[b_q][23:8];
						if (b_q == 3'd4) begin
							b_q <= '0; state_q <= ST_EMA_A;
						end else b_q <= b_q + 3'd1;
					end else if (cnt_q == 6'd0) begin
						num_q <= {lv_q[b_q], 32'd0};
						acc_q <= 64'(peak_q);
						rem_q <= '0; quo_q <= '0;
						cnt_q <= 6'd16;
					end else begin
						if (!trial[64]) rem_q <= trial[63:0];
						else rem_q <= {rem_q[62:0], num_q[63]};
						quo_q <= {quo_q[42:0], !trial[64]};
						num_q <= {num_q[62:0], 1'b0};
						if (cnt_q == 6'd63) begin
							cnt_q <= '0;
							gl_q[b_q] <= quo_q[43:15] != '0 ? 16'hFFFF
								: {quo_q[14:0], !trial[64]};
							if (b_q == 3'd4) begin
								b_q <= '0; state_q <= ST_EMA_A;
							end else b_q <= b_q + 3'd1;
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_EMA_A: begin
					acc_q <= 64'(mac);
					state_q <= ST_EMA_B;
				end
				ST_EMA_B: begin
					smooth_q[b_q] <= 16'((acc_q + 64'(32'(gl_q[b_q]) * 32'(fast_alpha_q))
						+ 64'd32768) >> 16);
					if (b_q == 3'd4) begin
						b_q <= '0; cnt_q <= '0; state_q <= ST_SEC;
					end else begin
						b_q <= b_q + 3'd1; state_q <= ST_EMA_A;
					end
				end
				ST_SEC: begin
					if (cnt_q == 6'd0) begin
						sec_lvl_q <= 16'((64'(32'(sec_lvl_q) * 32'(17'h10000 - 17'(slow_alpha_q)))
							+ 64'(32'(smooth_q[0]) * 32'(slow_alpha_q)) + 64'd32768) >> 16);
						cnt_q <= 6'd1;
					end else begin
						changed_q <= (sec_lvl_q > sec_ref_q ? sec_lvl_q - sec_ref_q
							: sec_ref_q - sec_lvl_q) > SECTION_THRESH;
						if ((sec_lvl_q > sec_ref_q ? sec_lvl_q - sec_ref_q
								: sec_ref_q - sec_lvl_q) > SECTION_THRESH)
							sec_ref_q <= sec_lvl_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the previous result has been transferred
					if (!m_axis_tvalid) begin
						m_axis_tvalid <= 1'b1;
						bin_idx_q <= '0;
						for (int i = 0; i < 4; i++) begin
							sums_q[i] <= '0; counts_q[i] <= '0;
						end
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
			if (state_q == ST_SQRT && cnt_q == 6'd32)
				lv_q[b_q + 3'd1] <= root_trial[65] ? {acc_q[30:0], 1'b0}
					: {acc_q[30:0], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && !m_axis_tvalid) begin
			m_axis_tdata <= {smooth_q[4], smooth_q[3], smooth_q[2], smooth_q[1], smooth_q[0],
				gl_q[4], gl_q[3], gl_q[2], gl_q[1], gl_q[0]};
			m_axis_tuser <= changed_q;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC) |-> !s_axis_tready) else $error("bin taken while busy");
	a_peak_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAIN) |-> (active_q == (peak_q > PEAK_FLOOR)))
		else $error("gain flag out of step with peak");
	a_out_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT) else $error("stray result");
endmodule
`default_nettype wire

### tb/sv/spectrum_band_energy_meter_tb.sv
// Self-checking testbench for the spectrum band energy meter: random and directed
// spectrum frames, a bit-exact band level predictor, scoreboard on every result.
// Depends on sbem_pkg and spectrum_band_energy_meter.
`default_nettype none
module spectrum_band_energy_meter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbem_pkg::*;

	localparam int BIN_LIMIT = 4096;
	localparam int SETTLE_CYCLES = 800;

	typedef struct {
		logic [15:0] mag;
		logic last;
	} bin_t;

	typedef struct {
		logic [159:0] levels;
		logic change;
	} frame_levels_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0; // bin_magnitude
	logic s_axis_tlast = 1'b0; // last_bin
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [159:0] m_axis_tdata; // level_overall .. avg_treble, 16 bits each
	logic m_axis_tuser; // section_flag
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_t cfg_data = '0;

	bin_t bin_q[$];
	frame_levels_t levels_q[$];
	logic s_took = 1'b0;
	int idle_pct = 11;
	int errors = 0;
	int frames_seen = 0;
	int bins_seen = 0;

	// predictor state and its copy of the registers
	logic [12:0] edge_sub, edge_bass, edge_mid;
	logic [15:0] alpha_fast, alpha_slow;
	logic [12:0] bin_pos;
	logic [43:0] band_sum[4];
	logic [12:0] band_cnt[4];
	logic [31:0] peak;
	logic [15:0] smooth[5];
	logic [15:0] sect_lvl, sect_ref;

	spectrum_band_energy_meter #(.MAX_BINS(BIN_LIMIT)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] blend(input logic [15:0] s, input logic [15:0] x,
			input logic [15:0] a);
		logic [63:0] acc;
		acc = 64'(s) * (64'd65536 - 64'(a)) + 64'(x) * 64'(a) + 64'd32768;
		return acc[31:16];
	endfunction

	function automatic logic [15:0] scale_level(input logic [31:0] lvl, input logic gain_on);
		logic [63:0] q;
		q = gain_on ? (64'(lvl) << 16) / 64'(peak) : 64'(lvl >> 8);
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic void reset_meter();
		edge_sub = 13'd2; edge_bass = 13'd6; edge_mid = 13'd86;
		alpha_fast = 16'd8192; alpha_slow = 16'd544;
		bin_pos = '0;
		for (int b = 0; b < 4; b++) begin
			band_sum[b] = '0;
			band_cnt[b] = '0;
		end
		peak = PEAK_FLOOR;
		for (int b = 0; b < 5; b++) smooth[b] = '0;
		sect_lvl = '0;
		sect_ref = '0;
	endfunction

	function automatic void apply_reg(input cfg_t w);
		case (w.index)
			REG_SUB_EDGE: edge_sub = w.value[12:0];
			REG_BASS_EDGE: edge_bass = w.value[12:0];
			REG_MID_EDGE: edge_mid = w.value[12:0];
			REG_FAST_ALPHA: alpha_fast = w.value;
			REG_SLOW_ALPHA: alpha_slow = w.value;
			default: ;
		endcase
	endfunction

	// accumulate one bin; on the marked bin queue the frame's levels
	function automatic void meter_bin(input bin_t bn);
		int band;
		logic [63:0] sum_next, mean, ov;
		logic [31:0] lvl[5];
		logic [15:0] outl[5];
		logic gain_on;
		logic [15:0] diff;
		frame_levels_t fr;
		if (bin_pos != 0) begin
			if (bin_pos < edge_sub) band = 0;
			else if (bin_pos < edge_bass) band = 1;
			else if (bin_pos < edge_mid) band = 2;
			else band = 3;
			sum_next = 64'(band_sum[band]) + 64'(bn.mag) * 64'(bn.mag);
			band_sum[band] = (sum_next > 64'(SUM_MAX)) ? SUM_MAX : sum_next[43:0];
			if (band_cnt[band] < COUNT_MAX) band_cnt[band]++;
		end
		bin_pos = (32'(bin_pos) + 1 >= BIN_LIMIT) ? 13'(BIN_LIMIT - 1) : bin_pos + 13'd1;
		if (!bn.last) return;
		for (int b = 0; b < 4; b++) begin
			mean = 0;
			if (band_cnt[b] != 0) begin
				mean = 64'(band_sum[b]) / 64'(band_cnt[b]);
				if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
			end
			lvl[b + 1] = 32'(int_sqrt(mean << 32));
		end
		ov = (64'(lvl[1]) * W_LOW + 64'(lvl[2]) * W_LOW + 64'(lvl[3]) * W_MID
			+ 64'(lvl[4]) * W_HIGH) >> 16;
		lvl[0] = ov[31:0];
		if (lvl[0] > peak) peak = lvl[0];
		peak = 32'((64'(peak) * 64'(PEAK_DECAY)) >> 32);
		gain_on = peak > PEAK_FLOOR;
		for (int b = 0; b < 5; b++) begin
			outl[b] = scale_level(lvl[b], gain_on);
			smooth[b] = blend(smooth[b], outl[b], alpha_fast);
			fr.levels[16*b +: 16] = outl[b];
			fr.levels[16*(b + 5) +: 16] = smooth[b];
		end
		sect_lvl = blend(sect_lvl, smooth[0], alpha_slow);
		diff = (sect_lvl > sect_ref) ? sect_lvl - sect_ref : sect_ref - sect_lvl;
		fr.change = diff > SECTION_THRESH;
		if (fr.change) sect_ref = sect_lvl;
		levels_q.push_back(fr);
		bin_pos = '0;
		for (int b = 0; b < 4; b++) begin
			band_sum[b] = '0;
			band_cnt[b] = '0;
		end
	endfunction

	always @(posedge clk) begin
		s_took <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			meter_bin('{s_axis_tdata, s_axis_tlast});
			bins_seen++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			frames_seen++;
			if (levels_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				frame_levels_t want;
				want = levels_q.pop_front();
				for (int f = 0; f < 10; f++) begin
					if (m_axis_tdata[16*f +: 16] !== want.levels[16*f +: 16]) begin
						errors++;
						if (errors <= 10)
							$display("frame %0d field %0d: expected %h got %h", frames_seen,
								f, want.levels[16*f +: 16], m_axis_tdata[16*f +: 16]);
					end
				end
				if (m_axis_tuser !== want.change) begin
					errors++;
					if (errors <= 10)
						$display("frame %0d section change: expected %b got %b",
							frames_seen, want.change, m_axis_tuser);
				end
			end
		end
	end

	// bin driver: advance on a completed transfer or an empty bus
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_took)) begin
			if (bin_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				bin_t bn;
				bn = bin_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= bn.mag;
				s_axis_tlast <= bn.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = '{idx, val};
		do @(posedge clk); while (!cfg_ready);
		apply_reg(cfg_data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_bands(input int e0, input int e1, input int e2, input int fa,
			input int sa);
		write_reg(REG_SUB_EDGE, 16'(e0));
		write_reg(REG_BASS_EDGE, 16'(e1));
		write_reg(REG_MID_EDGE, 16'(e2));
		write_reg(REG_FAST_ALPHA, 16'(fa));
		write_reg(REG_SLOW_ALPHA, 16'(sa));
	endtask

	function automatic logic [15:0] pick_mag();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			1: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_frame(input int len);
		for (int i = 0; i < len; i++) bin_q.push_back('{pick_mag(), i == len - 1});
	endtask

	// random frames until about n bins are queued; mostly short, a few long
	task automatic push_frames(input int n, input int long_len);
		int left;
		int len;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(long_len) + 1
				: $urandom_range(12) + 1;
			push_frame(len);
			left -= len;
		end
	endtask

	task automatic drain();
		while (bin_q.size() != 0 || s_axis_tvalid || levels_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		reset_meter();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// single-bin frames, extremes, a stray unmarked tail closed later
		bin_q.push_back('{16'hFFFF, 1'b1});
		bin_q.push_back('{16'h0000, 1'b1});
		for (int i = 0; i < 8; i++) bin_q.push_back('{16'hFFFF, i == 7});
		for (int i = 0; i < 6; i++) bin_q.push_back('{16'h0000, i == 5});
		bin_q.push_back('{16'h5555, 1'b0});
		bin_q.push_back('{16'hAAAA, 1'b0});
		bin_q.push_back('{16'h0001, 1'b0});
		bin_q.push_back('{16'h8000, 1'b0});
		bin_q.push_back('{16'h00FF, 1'b0});
		bin_q.push_back('{16'hFF00, 1'b0});
		bin_q.push_back('{16'h7FFF, 1'b1});
		drain();
		push_frames(90, 60);
		push_frame(3);
		drain();

		// extremes of every register, and ignored indexes
		set_bands(0, 0, 0, 65535, 65535);
		write_reg(REG_SLOW_ALPHA + 3'd1, 16'hFFFF);
		write_reg(REG_SLOW_ALPHA + 3'd3, 16'h0000);
		push_frames(50, 20);
		push_frame(2);
		drain();
		set_bands(4096, 4096, 4096, 0, 0);
		push_frames(50, 20);
		push_frame(2);
		drain();
		set_bands(8191, 8191, 8191, 1, 65535);
		push_frames(30, 20);
		push_frame(2);
		drain();

		// edges out of order, then a spread that puts bins in the bass, mid and treble bands
		set_bands(9, 3, 5, $urandom, $urandom);
		push_frames(50, 16);
		push_frame(4);
		drain();
		set_bands(1, 3, 7, $urandom, 65535);
		push_frames(50, 14);
		push_frame(5);
		drain();

		// reset values again, no idling, then a long full-scale frame
		idle_pct = 0;
		set_bands(2, 6, 86, 8192, 544);
		push_frames(40, 80);
		push_frame(1);
		drain();
		idle_pct = 11;
		for (int i = 0; i < 30; i++) bin_q.push_back('{16'hFFFF, i == 29});
		push_frame(6);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d bins in %0d frames over seven register settings,",
			bins_seen, frames_seen);
		$display("including unordered edges, extreme alphas and a long full-scale frame.");
		if (errors == 0 && levels_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, levels_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire
